// ----- rtl/core/bdq_pkg.sv -----
// Package for the bounded deque with search and move to front.
// Sizes, operation and status codes, and the controller-to-datapath command struct.
// No dependencies.
`timescale 1ns / 1ps

package bdq_pkg;

	// Store geometry
	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int FUNC_W = 4;
	localparam int STAT_W = 2;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd0;
	localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd1;
	localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd2;
	localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd3;
	localparam logic [FUNC_W-1:0] FN_PEEK_FIRST = 4'd4;
	localparam logic [FUNC_W-1:0] FN_PEEK_LAST  = 4'd5;
	localparam logic [FUNC_W-1:0] FN_ZERO_LAST  = 4'd6;
	localparam logic [FUNC_W-1:0] FN_SEARCH     = 4'd7;
	localparam logic [FUNC_W-1:0] FN_MOVE_FRONT = 4'd8;
	localparam logic [FUNC_W-1:0] FN_OVERWRITE  = 4'd9;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;     // capture the incoming transaction
		logic compare;  // register match vector and read word
		logic apply;    // update the store and load the result register
	} cmd_t;

endpackage

// ----- rtl/core/bounded_deque_search_move_front_unit.sv -----
// Bounded deque with search and move to front, top level.
// Instantiates bdq_ctrl and bdq_datapath; depends on bdq_pkg.
`timescale 1ns / 1ps

// An ordered store of up to 16 signed 32-bit words, index 0 at the front, that
// takes one operation per input transaction (push/pop at either end, peek,
// zero last, search, move to front, overwrite) and returns exactly one result
// transaction with data, found flag, found index, entry count and status.
// Each transaction is handled in order: the accepting edge captures it, the
// compare stage is then registered (one comparator per cell plus one read
// port), and apply then updates the shifting cell chain and loads the output
// register, which offers the result. The next input is accepted in the cycle
// after apply, so a new transaction is not taken until the last one has been
// applied. A pending result may wait in the output register while the next
// transaction is captured and compared; apply then stalls until the output
// register is drained. Cell contents are not reset; the entry count resets to
// zero.
module bounded_deque_search_move_front_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic        [bdq_pkg::FUNC_W-1:0]     func,
	input  logic signed [bdq_pkg::DATA_W-1:0]     value,
	input  logic        [bdq_pkg::IDX_W-1:0]      position,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [bdq_pkg::DATA_W-1:0]     data,
	output logic                                  found,
	output logic        [bdq_pkg::IDX_W-1:0]      found_index,
	output logic        [bdq_pkg::CNT_W-1:0]      entry_total,
	output logic        [bdq_pkg::STAT_W-1:0]     status
);

	bdq_pkg::cmd_t cmd;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	bdq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (func),
		.value       (value),
		.position    (position),
		.data        (data),
		.found       (found),
		.found_index (found_index),
		.entry_total (entry_total),
		.status      (status)
	);

`ifndef SYNTHESIS
	// One transaction in flight: no acceptance right after an acceptance
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a transaction was in flight");

	// Entry count never exceeds the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (entry_total <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH)))
		else $error("entry count above depth");

	// Full status only reported with a full store
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == bdq_pkg::ST_FULL) |->
		(entry_total == bdq_pkg::CNT_W'(bdq_pkg::DEPTH)))
		else $error("full status with store not full");

	// A found match implies a good status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (status == bdq_pkg::ST_OK))
		else $error("match reported with error status");
`endif

endmodule

// ----- rtl/core/bdq_ctrl.sv -----
// Controller for the bounded deque: sequences capture, compare and apply.
// Drives the input ready and output valid handshakes. Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output bdq_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_CMP   = 3'b010,
		S_APPLY = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   apply_fire;

	// Apply only when the result register is free or being drained
	assign apply_fire = (state_q == S_APPLY) && (!out_valid_q || out_ready);
	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;

	assign cmd.load    = in_valid && (state_q == S_IDLE);
	assign cmd.compare = (state_q == S_CMP);
	assign cmd.apply   = apply_fire;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:  if (in_valid) state_nxt = S_CMP;
			S_CMP:   state_nxt = S_APPLY;
			S_APPLY: if (apply_fire) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Output valid: set by apply, cleared when the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/bdq_datapath.sv -----
// Datapath for the bounded deque: shifting cell chain, per-cell comparators,
// read mux, update logic and result register. Depends on bdq_pkg.
`timescale 1ns / 1ps

module bdq_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bdq_pkg::cmd_t                         cmd,
	input  logic        [bdq_pkg::FUNC_W-1:0]     func,
	input  logic signed [bdq_pkg::DATA_W-1:0]     value,
	input  logic        [bdq_pkg::IDX_W-1:0]      position,
	output logic signed [bdq_pkg::DATA_W-1:0]     data,
	output logic                                  found,
	output logic        [bdq_pkg::IDX_W-1:0]      found_index,
	output logic        [bdq_pkg::CNT_W-1:0]      entry_total,
	output logic        [bdq_pkg::STAT_W-1:0]     status
);

	// Captured transaction
	logic        [bdq_pkg::FUNC_W-1:0] func_q;
	logic signed [bdq_pkg::DATA_W-1:0] value_q;
	logic        [bdq_pkg::IDX_W-1:0]  pos_q;

	// Store
	logic signed [bdq_pkg::DATA_W-1:0] cells_q [bdq_pkg::DEPTH];
	logic signed [bdq_pkg::DATA_W-1:0] cell_nxt [bdq_pkg::DEPTH];
	logic        [bdq_pkg::CNT_W-1:0]  occ_q;
	logic        [bdq_pkg::CNT_W-1:0]  occ_nxt;

	// Compare stage
	logic        [bdq_pkg::DEPTH-1:0]  match_s1;
	logic signed [bdq_pkg::DATA_W-1:0] rd_s1;
	logic        [bdq_pkg::IDX_W-1:0]  last_idx;
	logic        [bdq_pkg::IDX_W-1:0]  rd_addr;

	// Result
	logic signed [bdq_pkg::DATA_W-1:0] res_data;
	logic                              res_found;
	logic        [bdq_pkg::IDX_W-1:0]  res_fidx;
	logic        [bdq_pkg::STAT_W-1:0] res_status;
	logic signed [bdq_pkg::DATA_W-1:0] data_q;
	logic                              found_q;
	logic        [bdq_pkg::IDX_W-1:0]  fidx_q;
	logic        [bdq_pkg::CNT_W-1:0]  total_q;
	logic        [bdq_pkg::STAT_W-1:0] status_q;

	logic full;
	logic empty;
	logic pos_bad;

	assign last_idx = bdq_pkg::IDX_W'(occ_q - bdq_pkg::CNT_W'(1));
	assign rd_addr  = (func_q == bdq_pkg::FN_MOVE_FRONT) ? pos_q : last_idx;
	assign full     = (occ_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
	assign empty    = (occ_q == '0);
	assign pos_bad  = ({1'b0, pos_q} >= occ_q);

	// Capture the incoming transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			value_q <= value;
			pos_q   <= position;
		end
	end

	// Compare stage: one comparator per cell, single read port
	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
				match_s1[i] <= (cells_q[i] == value_q) &&
					(bdq_pkg::CNT_W'(i) < occ_q);
			end
			rd_s1 <= cells_q[rd_addr];
		end
	end

	// Apply: per-cell next value, occupancy and result
	always_comb begin
		for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
			cell_nxt[i] = cells_q[i];
		end
		occ_nxt    = occ_q;
		res_data   = '0;
		res_found  = 1'b0;
		res_fidx   = '0;
		res_status = bdq_pkg::ST_OK;
		unique case (func_q)
			bdq_pkg::FN_PUSH_FRONT: begin
				if (full) begin
					res_status = bdq_pkg::ST_FULL;
				end else begin
					for (int i = 1; i < bdq_pkg::DEPTH; i++) begin
						cell_nxt[i] = cells_q[i-1];
					end
					cell_nxt[0] = value_q;
					occ_nxt     = occ_q + bdq_pkg::CNT_W'(1);
				end
			end
			bdq_pkg::FN_PUSH_BACK: begin
				if (full) begin
					res_status = bdq_pkg::ST_FULL;
				end else begin
					cell_nxt[bdq_pkg::IDX_W'(occ_q)] = value_q;
					occ_nxt = occ_q + bdq_pkg::CNT_W'(1);
				end
			end
			bdq_pkg::FN_POP_FRONT: begin
				if (empty) begin
					res_status = bdq_pkg::ST_EMPTY;
				end else begin
					res_data = cells_q[0];
					for (int i = 0; i < bdq_pkg::DEPTH - 1; i++) begin
						cell_nxt[i] = cells_q[i+1];
					end
					occ_nxt = occ_q - bdq_pkg::CNT_W'(1);
				end
			end
			bdq_pkg::FN_POP_BACK: begin
				if (empty) begin
					res_status = bdq_pkg::ST_EMPTY;
				end else begin
					res_data = rd_s1;
					occ_nxt  = occ_q - bdq_pkg::CNT_W'(1);
				end
			end
			bdq_pkg::FN_PEEK_FIRST: begin
				if (empty) res_status = bdq_pkg::ST_EMPTY;
				else res_data = cells_q[0];
			end
			bdq_pkg::FN_PEEK_LAST: begin
				if (empty) res_status = bdq_pkg::ST_EMPTY;
				else res_data = rd_s1;
			end
			bdq_pkg::FN_ZERO_LAST: begin
				if (empty) res_status = bdq_pkg::ST_EMPTY;
				else cell_nxt[last_idx] = '0;
			end
			bdq_pkg::FN_SEARCH: begin
				if (empty) begin
					res_status = bdq_pkg::ST_EMPTY;
				end else begin
					// priority encode: lowest matching index wins
					for (int i = bdq_pkg::DEPTH - 1; i >= 0; i--) begin
						if (match_s1[i]) begin
							res_found = 1'b1;
							res_fidx  = bdq_pkg::IDX_W'(i);
						end
					end
				end
			end
			bdq_pkg::FN_MOVE_FRONT: begin
				if (pos_bad) begin
					res_status = bdq_pkg::ST_RANGE;
				end else begin
					for (int i = 1; i < bdq_pkg::DEPTH; i++) begin
						if (bdq_pkg::IDX_W'(i) <= pos_q) cell_nxt[i] = cells_q[i-1];
					end
					cell_nxt[0] = rd_s1;
				end
			end
			bdq_pkg::FN_OVERWRITE: begin
				if (pos_bad) res_status = bdq_pkg::ST_RANGE;
				else cell_nxt[pos_q] = value_q;
			end
			default: begin
				// unused codes: no operation
			end
		endcase
	end

	// Store update
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			for (int i = 0; i < bdq_pkg::DEPTH; i++) begin
				cells_q[i] <= cell_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.apply) begin
			occ_q <= occ_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			data_q   <= res_data;
			found_q  <= res_found;
			fidx_q   <= res_fidx;
			total_q  <= occ_nxt;
			status_q <= res_status;
		end
	end

	assign data        = data_q;
	assign found       = found_q;
	assign found_index = fidx_q;
	assign entry_total = total_q;
	assign status      = status_q;

endmodule
